[rtl/tab_pkg.sv]
package tab_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Pixel layouts selected by the format register.
    typedef enum logic [1:0] {
        FMT_RGBA5551 = 2'd0,
        FMT_IA8      = 2'd1,
        FMT_IA4      = 2'd2,
        FMT_RAW      = 2'd3
    } fmt_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FORMAT = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // Item kinds carried on the input tuser.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Neighbor offset codes along one axis.
    localparam logic [1:0] POS_LO  = 2'd0;
    localparam logic [1:0] POS_MID = 2'd1;
    localparam logic [1:0] POS_HI  = 2'd2;

    // Read sequence: nine window reads, the center being the fifth.
    localparam logic [3:0] CENTER_STEP = 4'd4;
    localparam logic [3:0] LAST_STEP   = 4'd9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FINISH
    } state_t;

    // Opaque neighbor count and per-channel color sums.
    typedef struct packed {
        logic [3:0] n;
        logic [7:0] s0;
        logic [7:0] s1;
        logic [7:0] s2;
    } acc_t;

    function automatic logic [15:0] fmt_mask(input fmt_t f);
        logic [15:0] m;
        unique case (f)
            FMT_IA8: m = 16'h00FF;
            FMT_IA4: m = 16'h000F;
            default: m = 16'hFFFF;
        endcase
        return m;
    endfunction

    function automatic logic is_opaque(input fmt_t f, input logic [15:0] q);
        return (f == FMT_IA8) ? (|q[3:0]) : q[0];
    endfunction

    // Ceiling of 2^16 / n; exact floor quotients for numerators below 512.
    function automatic logic [16:0] recip(input logic [3:0] n);
        logic [16:0] r;
        unique case (n)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] rmean(input logic [7:0] sum, input logic [3:0] n);
        logic [8:0]  x;
        logic [25:0] prod;
        x    = {1'b0, sum} + {6'b0, n[3:1]};
        prod = 26'(x) * 26'(recip(n));
        return prod[20:16];
    endfunction

endpackage

[rtl/tab_recolor.sv]
module tab_recolor
    import tab_pkg::*;
(
    input  fmt_t        fmt,
    input  logic [15:0] center,
    input  acc_t        acc,
    output logic [15:0] pixel
);

    logic [4:0] m0;
    logic [4:0] m1;
    logic [4:0] m2;

    assign m0 = rmean(acc.s0, acc.n);
    assign m1 = rmean(acc.s1, acc.n);
    assign m2 = rmean(acc.s2, acc.n);

    always_comb
    begin
        if (fmt == FMT_RAW || is_opaque(fmt, center) || acc.n == 4'd0)
        begin
            pixel = center;
        end
        else
        begin
            unique case (fmt)
                FMT_RGBA5551: pixel = {m0, m1, m2, 1'b0};
                FMT_IA8:      pixel = {8'd0, m0[3:0], 4'd0};
                default:      pixel = {12'd0, m0[2:0], 1'b0};
            endcase
        end
    end

endmodule

[rtl/texture_alpha_bleed_3x3.sv]
// Alpha bleeding of a texture over a 3x3 neighborhood.
// Input stream: s_axis carries one item per transfer, tuser[0] selects a pixel
// (0) or a flush (1), tdata holds the pixel. Pixels arrive in raster order.
// Output stream: m_axis returns the pixels in the same order, tlast marks the
// final pixel of the image. A transparent pixel with opaque neighbors gets the
// rounded mean color of those neighbors and stays transparent; raw passes as is.
// A pixel leaves once the image width plus one more pixels have arrived; after
// the whole image is in, each further item, flush or pixel, drains one pending pixel.
// An item that yields no result is accepted and goes no further. An item that
// yields a result passes through acceptance, nine neighborhood reads one by one
// through the single read port of the line memory, a step in which the last read
// joins the sums, and recoloring, which waits while the output register is full.
// One item is in work at a time.
// The result sits in an output register; a stalled receiver holds it there
// and the block keeps working until the next result finds that register full.
// Reset clears the counters and the output; the line memory needs no clearing.
// A write (cfg_we, cfg_index, cfg_data) to format, width or height restarts the stream.
module texture_alpha_bleed_3x3
    import tab_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // pixel_in
    input  logic [0:0]  s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // pixel_out
    output logic        m_axis_tlast,   // last_of_image
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int LINE_DEPTH = 2 * MAX_WIDTH + 3;
    localparam int AW = $clog2(LINE_DEPTH);
    localparam int UW = AW + 2;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    fmt_t        format_reg;
    logic [9:0]  width_reg;
    logic [10:0] height_reg;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [WW-1:0] w_last;
    logic [HW-1:0] h_last;

    state_t state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [WW-1:0] in_col_reg, in_col_next;
    logic [HW-1:0] in_row_reg, in_row_next;
    logic [AW-1:0] in_addr_reg, in_addr_next;
    logic [WW-1:0] out_col_reg, out_col_next;
    logic [HW-1:0] out_row_reg, out_row_next;
    logic [AW-1:0] out_addr_reg, out_addr_next;
    acc_t acc_reg, acc_next;
    logic [15:0] center_reg, center_next;
    logic out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;
    logic out_last_reg, out_last_next;

    logic [15:0] line_mem [LINE_DEPTH];
    logic [15:0] rd_data_reg;
    logic rd_valid_reg, rd_valid_next;
    logic nb_ok_reg, nb_ok_next;
    logic is_center_reg, is_center_next;
    logic [AW-1:0] rd_addr;
    logic mem_we;

    logic complete;
    logic last_out;
    logic restart;
    logic [1:0] dyc;
    logic [1:0] dxc;
    logic [UW-1:0] u;
    logic [15:0] q;
    logic [15:0] recolored;

    // Effective geometry: zero reads as one, oversize saturates.
    always_comb
    begin
        if (width_reg == 10'd0)
            w_eff = WW'(1);
        else if (13'(width_reg) > 13'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
        if (height_reg == 11'd0)
            h_eff = HW'(1);
        else if (13'(height_reg) > 13'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(height_reg);
    end

    assign w_last   = w_eff - WW'(1);
    assign h_last   = h_eff - HW'(1);
    assign complete = (in_row_reg >= h_eff);
    assign last_out = (out_row_reg == h_last) && (out_col_reg == w_last);

    // Neighbor position of the current read step.
    always_comb
    begin
        unique case (step_reg)
            4'd0:    begin dyc = POS_LO;  dxc = POS_LO;  end
            4'd1:    begin dyc = POS_LO;  dxc = POS_MID; end
            4'd2:    begin dyc = POS_LO;  dxc = POS_HI;  end
            4'd3:    begin dyc = POS_MID; dxc = POS_LO;  end
            4'd4:    begin dyc = POS_MID; dxc = POS_MID; end
            4'd5:    begin dyc = POS_MID; dxc = POS_HI;  end
            4'd6:    begin dyc = POS_HI;  dxc = POS_LO;  end
            4'd7:    begin dyc = POS_HI;  dxc = POS_MID; end
            4'd8:    begin dyc = POS_HI;  dxc = POS_HI;  end
            default: begin dyc = POS_MID; dxc = POS_MID; end
        endcase
    end

    // Ring address of the neighbor; the offset is biased by the depth so that
    // the sum never goes negative, then folded back into range.
    always_comb
    begin
        u = UW'(out_addr_reg) + UW'(LINE_DEPTH);
        if (dyc == POS_LO)
            u = u - UW'(w_eff);
        else if (dyc == POS_HI)
            u = u + UW'(w_eff);
        u = u + UW'(dxc) - UW'(1);
        if (u >= UW'(2 * LINE_DEPTH))
            u = u - UW'(2 * LINE_DEPTH);
        if (u >= UW'(LINE_DEPTH))
            u = u - UW'(LINE_DEPTH);
        rd_addr = AW'(u);
    end

    assign q = rd_data_reg & fmt_mask(format_reg);

    tab_recolor u_recolor (
        .fmt    (format_reg),
        .center (center_reg),
        .acc    (acc_reg),
        .pixel  (recolored)
    );

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        in_addr_next   = in_addr_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_addr_next  = out_addr_reg;
        acc_next       = acc_reg;
        center_next    = center_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        mem_we         = 1'b0;
        rd_valid_next  = 1'b0;
        nb_ok_next     = 1'b0;
        is_center_next = 1'b0;
        restart        = 1'b0;
        s_axis_tready  = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser[0] == OP_PIXEL && !complete)
                    begin
                        mem_we       = 1'b1;
                        in_addr_next = (in_addr_reg == AW'(LINE_DEPTH - 1)) ?
                                       '0 : in_addr_reg + AW'(1);
                        if (in_col_reg == w_last)
                        begin
                            in_col_next = '0;
                            in_row_next = in_row_reg + HW'(1);
                        end
                        else
                        begin
                            in_col_next = in_col_reg + WW'(1);
                        end
                        // A full row plus one pixel is in once the row count is nonzero.
                        if (in_row_reg != '0)
                        begin
                            state_next = ST_READ;
                            step_next  = '0;
                            acc_next   = '0;
                        end
                    end
                    else if (complete)
                    begin
                        state_next = ST_READ;
                        step_next  = '0;
                        acc_next   = '0;
                    end
                end
            end
            ST_READ:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    step_next      = step_reg + 4'd1;
                    rd_valid_next  = 1'b1;
                    is_center_next = (step_reg == CENTER_STEP);
                    nb_ok_next     = !((dyc == POS_LO && out_row_reg == '0) ||
                                       (dyc == POS_HI && out_row_reg == h_last) ||
                                       (dxc == POS_LO && out_col_reg == '0) ||
                                       (dxc == POS_HI && out_col_reg == w_last));
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = recolored;
                    out_last_next  = last_out;
                    state_next     = ST_IDLE;
                    if (last_out)
                    begin
                        restart = 1'b1;
                    end
                    else
                    begin
                        out_addr_next = (out_addr_reg == AW'(LINE_DEPTH - 1)) ?
                                        '0 : out_addr_reg + AW'(1);
                        if (out_col_reg == w_last)
                        begin
                            out_col_next = '0;
                            out_row_next = out_row_reg + HW'(1);
                        end
                        else
                        begin
                            out_col_next = out_col_reg + WW'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Data read in the previous step joins the sums.
        if (rd_valid_reg)
        begin
            if (is_center_reg)
            begin
                center_next = q;
            end
            else if (nb_ok_reg && is_opaque(format_reg, q))
            begin
                acc_next.n = acc_reg.n + 4'd1;
                unique case (format_reg)
                    FMT_IA8:
                        acc_next.s0 = acc_reg.s0 + {4'd0, q[7:4]};
                    FMT_IA4:
                        acc_next.s0 = acc_reg.s0 + {5'd0, q[3:1]};
                    default:
                    begin
                        acc_next.s0 = acc_reg.s0 + {3'd0, q[15:11]};
                        acc_next.s1 = acc_reg.s1 + {3'd0, q[10:6]};
                        acc_next.s2 = acc_reg.s2 + {3'd0, q[5:1]};
                    end
                endcase
            end
        end

        if (cfg_we && (cfg_index == CFG_FORMAT || cfg_index == CFG_WIDTH ||
                       cfg_index == CFG_HEIGHT))
        begin
            restart = 1'b1;
        end

        if (restart)
        begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_addr_next  = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_addr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg    <= FMT_RGBA5551;
            width_reg     <= 10'd1;
            height_reg    <= 11'd1;
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_addr_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_addr_reg  <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FORMAT: format_reg <= fmt_t'(cfg_data[1:0]);
                    CFG_WIDTH:  width_reg  <= cfg_data[9:0];
                    CFG_HEIGHT: height_reg <= cfg_data;
                    default:    ;
                endcase
            end
            state_reg     <= state_next;
            step_reg      <= step_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            in_addr_reg   <= in_addr_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            out_addr_reg  <= out_addr_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            rd_valid_reg  <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        center_reg    <= center_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        nb_ok_reg     <= nb_ok_next;
        is_center_reg <= is_center_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[in_addr_reg] <= s_axis_tdata;
        rd_data_reg <= line_mem[rd_addr];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (step_reg <= LAST_STEP))
        else $error("read step out of range");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg.n <= 4'd8)
        else $error("more than eight opaque neighbors counted");

    a_out_col: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (out_col_reg <= w_last && out_row_reg <= h_last))
        else $error("output position outside the image");

    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> !rd_valid_reg)
        else $error("neighborhood read still in flight at recolor");

endmodule

[test/testbench.sv]
module testbench;
    import tab_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 2 * MAX_WIDTH_DEF + 3;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic        op;
        logic [15:0] pix;
    } texel_item_t;

    typedef struct {
        logic [15:0] pix;
        logic        last;
    } texel_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;

    texel_item_t   pending_items[$];
    texel_result_t bled_expected[$];

    // Shadow state of the block.
    fmt_t        sh_fmt;
    logic [9:0]  sh_width;
    logic [10:0] sh_height;
    logic [15:0] sh_store[STORE_DEPTH];
    int          sh_col;
    int          sh_row;
    int          sh_out;

    int  errors;
    int  cycles;
    int  src_gap;
    int  sink_stall;
    bit  in_taken;
    bit  src_burst;
    bit  sink_burst;
    int  random_items;

    texture_alpha_bleed_3x3 u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int eff_w();
        if (sh_width == 0) return 1;
        return (sh_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(sh_width);
    endfunction

    function automatic int eff_h();
        if (sh_height == 0) return 1;
        return (sh_height > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(sh_height);
    endfunction

    function automatic logic [15:0] layout_mask();
        if (sh_fmt == FMT_IA8) return 16'h00FF;
        if (sh_fmt == FMT_IA4) return 16'h000F;
        return 16'hFFFF;
    endfunction

    function automatic bit texel_opaque(logic [15:0] q);
        if (sh_fmt == FMT_IA8) return q[3:0] != 4'd0;
        return q[0];
    endfunction

    function automatic int round_mean(int sum, int n);
        return (sum + n / 2) / n;
    endfunction

    // Color of raster index k after bleeding from its opaque neighbors.
    function automatic logic [15:0] bleed_texel(int k, int w, int h);
        int row;
        int col;
        int ny;
        int nx;
        int s0;
        int s1;
        int s2;
        int n;
        logic [15:0] mask;
        logic [15:0] p;
        logic [15:0] q;
        row = k / w;
        col = k % w;
        mask = layout_mask();
        p = sh_store[k % STORE_DEPTH] & mask;
        s0 = 0;
        s1 = 0;
        s2 = 0;
        n = 0;
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                ny = row + dy;
                nx = col + dx;
                if (ny < 0 || nx < 0 || ny >= h || nx >= w) continue;
                q = sh_store[(ny * w + nx) % STORE_DEPTH] & mask;
                if ((dy == 0 && dx == 0) || !texel_opaque(q)) continue;
                n++;
                if (sh_fmt == FMT_RGBA5551) begin
                    s0 += q[15:11];
                    s1 += q[10:6];
                    s2 += q[5:1];
                end else if (sh_fmt == FMT_IA8) begin
                    s0 += q[7:4];
                end else begin
                    s0 += q[3:1];
                end
            end
        end
        if (sh_fmt == FMT_RAW || texel_opaque(p) || n == 0) return p;
        if (sh_fmt == FMT_RGBA5551)
            return 16'((round_mean(s0, n) << 11) | (round_mean(s1, n) << 6)
                       | (round_mean(s2, n) << 1));
        if (sh_fmt == FMT_IA8) return 16'(round_mean(s0, n) << 4);
        return 16'(round_mean(s0, n) << 1);
    endfunction

    task automatic predict_item(texel_item_t it);
        int w;
        int h;
        int total;
        int received;
        bit complete;
        bit emit;
        texel_result_t r;
        w = eff_w();
        h = eff_h();
        total = w * h;
        complete = sh_row >= h;
        emit = 0;
        if (it.op == OP_PIXEL && !complete) begin
            received = sh_row * w + sh_col;
            sh_store[received % STORE_DEPTH] = it.pix;
            received++;
            sh_col++;
            if (sh_col >= w) begin
                sh_col = 0;
                sh_row++;
            end
            emit = received >= w + 1;
        end else if (complete) begin
            emit = sh_out < total;
        end
        if (emit) begin
            r.pix = bleed_texel(sh_out, w, h);
            r.last = (sh_out == total - 1);
            bled_expected.push_back(r);
            if (r.last) begin
                sh_col = 0;
                sh_row = 0;
                sh_out = 0;
            end else begin
                sh_out++;
            end
        end
    endtask

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        errors++;
        $display("mismatch %s: got %h, expected %h", what, got, want);
    endtask

    function automatic int pick_idle(bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 15);
        if (r < 9) return 0;
        if (r < 15) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Source side: a new item is presented once the last one has been taken.
    always @(negedge clk) begin
        texel_item_t it;
        if (rst_n) begin
            if (!s_axis_tvalid || in_taken) begin
                in_taken = 0;
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    s_axis_tdata  <= it.pix;
                    s_axis_tuser  <= it.op;
                    s_axis_tvalid <= 1'b1;
                    src_gap = pick_idle(src_burst);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n) begin
            if (sink_stall > 0) begin
                sink_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                sink_stall = pick_idle(sink_burst);
            end
        end
    end

    always @(posedge clk) begin
        texel_item_t it;
        texel_result_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_taken = 1;
                it.op = s_axis_tuser[0];
                it.pix = s_axis_tdata;
                predict_item(it);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (bled_expected.size() == 0) begin
                    report_mismatch("unexpected transfer", m_axis_tdata, 16'h0);
                end else begin
                    want = bled_expected.pop_front();
                    if (m_axis_tdata !== want.pix)
                        report_mismatch("pixel_out", m_axis_tdata, want.pix);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last_of_image", 16'(m_axis_tlast), 16'(want.last));
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_axis_tvalid || bled_expected.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_FORMAT) sh_fmt = fmt_t'(value[1:0]);
        else if (idx == CFG_WIDTH) sh_width = value[9:0];
        else sh_height = value;
        sh_col = 0;
        sh_row = 0;
        sh_out = 0;
    endtask

    function automatic logic [15:0] gen_texel(bit extremes);
        logic [15:0] p;
        if (extremes) begin
            case ($urandom_range(0, 3))
                0: p = 16'h0000;
                1: p = 16'hFFFF;
                2: p = 16'hFFFE;
                default: p = 16'hFFF0;
            endcase
        end else begin
            p = 16'($urandom());
            if ($urandom_range(0, 1)) p[3:0] = 4'd0;
        end
        return p;
    endfunction

    // One image: pixels, optional stray flushes, then, unless truncated, the drain.
    task automatic run_image(logic [1:0] f, logic [10:0] wv, logic [10:0] hv,
                             bit extremes, bit noisy, bit truncate);
        int total;
        int cut;
        texel_item_t it;
        write_reg(CFG_FORMAT, {9'd0, f});
        write_reg(CFG_WIDTH, wv);
        write_reg(CFG_HEIGHT, hv);
        src_burst = $urandom_range(0, 4) == 0;
        sink_burst = $urandom_range(0, 4) == 0;
        total = eff_w() * eff_h();
        cut = truncate ? $urandom_range(0, total - 1) : total;
        for (int k = 0; k < cut; k++) begin
            if (noisy && $urandom_range(0, 9) == 0) begin
                it.op = OP_FLUSH;
                it.pix = 16'($urandom());
                pending_items.push_back(it);
            end
            it.op = OP_PIXEL;
            it.pix = gen_texel(extremes);
            pending_items.push_back(it);
        end
        if (!truncate) begin
            for (int k = 0; k < eff_w() + 1 + (noisy ? $urandom_range(0, 2) : 0); k++) begin
                // A pixel after the image is complete drains like a flush.
                it.op = (noisy && $urandom_range(0, 3) == 0) ? OP_PIXEL : OP_FLUSH;
                it.pix = 16'($urandom());
                pending_items.push_back(it);
            end
        end
        random_items += cut + eff_w() + 1;
        wait_idle();
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 16'h0;
        s_axis_tuser = OP_PIXEL;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_FORMAT;
        cfg_data = 11'd0;
        errors = 0;
        cycles = 0;
        src_gap = 0;
        sink_stall = 0;
        in_taken = 0;
        src_burst = 0;
        sink_burst = 0;
        random_items = 0;
        sh_fmt = FMT_RGBA5551;
        sh_width = 10'd1;
        sh_height = 11'd1;
        sh_col = 0;
        sh_row = 0;
        sh_out = 0;
        for (int i = 0; i < STORE_DEPTH; i++) sh_store[i] = 16'h0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // A single column with its height saturated to the maximum goes first; its
        // pixels have no neighbor to the left or right of the center.
        run_image(FMT_RGBA5551, 11'd1, 11'd2047, 0, 0, 0);
        run_image(FMT_RGBA5551, 11'd1023, 11'd2, 0, 0, 0);
        run_image(FMT_RGBA5551, 11'd3, 11'd3, 1, 0, 0);
        run_image(FMT_IA8, 11'd3, 11'd3, 1, 1, 0);
        run_image(FMT_IA4, 11'd4, 11'd2, 1, 1, 0);
        run_image(FMT_RAW, 11'd2, 11'd2, 1, 0, 0);
        run_image(FMT_RGBA5551, 11'd0, 11'd0, 1, 1, 0);
        run_image(FMT_IA8, 11'd5, 11'd3, 0, 0, 1);

        random_items = 0;
        while (random_items < 600) begin
            run_image(($urandom_range(0, 9) == 0) ? FMT_RAW : 2'($urandom_range(0, 2)),
                      ($urandom_range(0, 15) == 0) ? 11'($urandom_range(0, 40))
                                                   : 11'($urandom_range(1, 6)),
                      11'($urandom_range(1, 5)),
                      $urandom_range(0, 7) == 0, $urandom_range(0, 2) == 0,
                      $urandom_range(0, 7) == 0);
        end

        wait_idle();
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/tab_pkg.sv
rtl/tab_recolor.sv
rtl/texture_alpha_bleed_3x3.sv
test/testbench.sv
